// ===== hdl/utr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utr_pkg
// shared constants, types and the digit-to-character map for the
// unsigned-to-radix-digits unit
// ----------------------------------------------------------------------------
package utr_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 64;
    localparam int unsigned MAX_DIGITS_DEF  = 64;

    localparam int unsigned IN_VALUE_W = 64;
    localparam int unsigned RADIX_W    = 6;
    localparam int unsigned CHAR_W     = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_LOWER_A  = 8'h61;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic store_digit;
        logic out_load;
        logic rd_dec;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic quot_zero;
        logic count_full;
        logic rd_first;
        logic out_free;
    } t_status;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_LIMIT) begin
            c = CHAR_ZERO + {2'b00, d};
        end else begin
            c = CHAR_LOWER_A + {2'b00, d - DECIMAL_LIMIT};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/utr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utr_ctrl
// sequencer: runs one bit-serial division per digit, stores digits, then
// reads them back most significant first into the output register
// ----------------------------------------------------------------------------
module utr_ctrl #(
    parameter int unsigned VALUE_WIDTH = utr_pkg::VALUE_WIDTH_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  utr_pkg::t_status i_status,
    output utr_pkg::t_cmd    o_cmd
);
    import utr_pkg::*;

    localparam int unsigned BIT_W = $clog2(VALUE_WIDTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [BIT_W-1:0] r_bit_cnt, n_bit_cnt;
    logic             bit_last;

    assign bit_last   = (r_bit_cnt == BIT_W'(VALUE_WIDTH - 1));
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        o_cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_bit_cnt  = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_bit_cnt      = r_bit_cnt + 1'b1;
                if (bit_last) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                o_cmd.store_digit = 1'b1;
                n_bit_cnt         = '0;
                if (i_status.quot_zero || i_status.count_full) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_RD: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_status.rd_first) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.rd_dec = 1'b1;
                        n_state      = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bit_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
        end
    end

    a_div_starts_at_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DIV) ##1 (r_state == ST_DIV) |-> (r_bit_cnt == '0))
        else $error("division entered with nonzero bit count");

    a_store_after_full_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STORE) |-> $past(r_state == ST_DIV && bit_last))
        else $error("digit stored before division finished");

    a_no_accept_when_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == ST_IDLE))
        else $error("item taken while busy");

endmodule
`default_nettype wire

// ===== hdl/utr_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utr_dpath
// restoring bit-serial divider by the radix, digit memory, read pointer and
// output register
// ----------------------------------------------------------------------------
module utr_dpath #(
    parameter int unsigned VALUE_WIDTH = utr_pkg::VALUE_WIDTH_DEF,
    parameter int unsigned MAX_DIGITS  = utr_pkg::MAX_DIGITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [utr_pkg::IN_VALUE_W-1:0]     i_value,
    input  wire  [utr_pkg::RADIX_W-1:0]        i_radix,
    input  utr_pkg::t_cmd                      i_cmd,
    output utr_pkg::t_status                   o_status,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [utr_pkg::CHAR_W-1:0]         o_digit_char,
    output logic                               o_last_digit
);
    import utr_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int unsigned IDX_W = $clog2(MAX_DIGITS);

    logic [VALUE_WIDTH-1:0] r_quot;
    logic [RADIX_W-1:0]     r_rem;
    logic [RADIX_W-1:0]     r_radix;
    logic [CNT_W-1:0]       r_count;
    logic [IDX_W-1:0]       r_rd_idx;
    logic [RADIX_W-1:0]     r_rd_data;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_out_char;
    logic                   r_out_last;

    logic [RADIX_W-1:0]     digit_mem [MAX_DIGITS];

    logic [RADIX_W-1:0]     radix_clamped;
    logic [RADIX_W:0]       trial;
    logic                   trial_ge;
    logic                   out_free;

    always_comb begin
        if (i_radix < RADIX_MIN) begin
            radix_clamped = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            radix_clamped = RADIX_MAX;
        end else begin
            radix_clamped = i_radix;
        end
    end

    // one restoring step: bring down the next dividend bit
    assign trial    = {r_rem, r_quot[VALUE_WIDTH-1]};
    assign trial_ge = (trial >= {1'b0, r_radix});
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.quot_zero  = (r_quot == '0);
    assign o_status.count_full = (r_count == CNT_W'(MAX_DIGITS - 1));
    assign o_status.rd_first   = (r_rd_idx == '0);
    assign o_status.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= '0;
        end else if (i_cmd.store_digit) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot  <= i_value[VALUE_WIDTH-1:0];
            r_radix <= radix_clamped;
            r_rem   <= '0;
        end else if (i_cmd.div_step) begin
            r_quot <= {r_quot[VALUE_WIDTH-2:0], trial_ge};
            if (trial_ge) begin
                r_rem <= RADIX_W'(trial - {1'b0, r_radix});
            end else begin
                r_rem <= trial[RADIX_W-1:0];
            end
        end else if (i_cmd.store_digit) begin
            r_rem <= '0;
        end
    end

    // read pointer starts at the most significant stored digit
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_digit) begin
            r_rd_idx <= r_count[IDX_W-1:0];
        end else if (i_cmd.rd_dec) begin
            r_rd_idx <= r_rd_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_digit) begin
            digit_mem[r_count[IDX_W-1:0]] <= r_rem;
        end
        r_rd_data <= digit_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_char <= digit_to_char(r_rd_data);
            r_out_last <= (r_rd_idx == '0);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;

    a_out_load_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while held");

    a_rem_below_radix : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_radix))
        else $error("partial remainder not below radix");

    a_store_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store_digit |-> (r_count < CNT_W'(MAX_DIGITS)))
        else $error("digit store overflow");

endmodule
`default_nettype wire

// ===== hdl/unsigned_to_radix_digits_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_to_radix_digits_unit
// unsigned integer to ascii text in a radix from 2 to 36
// ----------------------------------------------------------------------------
// Takes one item (value, radix) and returns its digits as ascii characters,
// most significant first, one output item per digit, with o_last_digit set
// on the least significant digit. Digits 0-9 map to '0'-'9' and 10-35 to
// 'a'-'z'; zero gives the single character '0'. A radix below 2 is used as
// 2, above 36 as 36. Only the low VALUE_WIDTH bits of the value count, and
// at most MAX_DIGITS (least significant) digits are produced. One item is
// worked at a time: each digit is found by the bit-serial restoring
// divider (one quotient bit per cycle plus a store step), and the digits
// are then read back from the digit memory into the output register, each
// through a read step and a load step that waits while the output
// register is held. The input is taken again as soon as the last digit
// sits in the output register.
// ----------------------------------------------------------------------------
module unsigned_to_radix_digits_unit #(
    parameter int unsigned VALUE_WIDTH = utr_pkg::VALUE_WIDTH_DEF,
    parameter int unsigned MAX_DIGITS  = utr_pkg::MAX_DIGITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // input item channel
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [utr_pkg::IN_VALUE_W-1:0] i_value,
    input  wire  [utr_pkg::RADIX_W-1:0]    i_radix,
    // digit item channel
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [utr_pkg::CHAR_W-1:0]     o_digit_char,
    output logic                           o_last_digit
);
    import utr_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: idle, divide, store, read, load
    utr_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // divider, digit memory and output register
    utr_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule
`default_nettype wire

// ===== bench/tb_unsigned_to_radix_digits_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unsigned_to_radix_digits_unit
// self-checking bench for the unsigned-to-radix-digits unit
// ----------------------------------------------------------------------------
// Sends (value, radix) items and predicts the ascii digit string of each one,
// most significant first, with the last-digit flag on the final character.
// Every digit coming out is compared against the oldest predicted character.
// Directed items cover zero, single digits, radix clamping and full-width
// values; random items follow with random gaps on the sender and random
// stalls on the receiver, plus stretches with no idling at all.
// ----------------------------------------------------------------------------
module tb_unsigned_to_radix_digits_unit;

    import utr_pkg::*;

    localparam int unsigned VALUE_WIDTH    = VALUE_WIDTH_DEF;
    localparam int unsigned MAX_DIGITS     = MAX_DIGITS_DEF;
    // longest quiet stretch: all 64 digits of a full binary value divided out
    // before the first digit shows, plus gaps and stalls, taken several times over
    localparam int unsigned WATCHDOG_LIMIT = 30000;
    localparam int unsigned RANDOM_ITEMS   = 88;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_digit;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  in_valid = 1'b0;
    logic [IN_VALUE_W-1:0] in_value = '0;
    logic [RADIX_W-1:0]    in_radix = '0;
    logic                  out_stall = 1'b0;

    wire                   o_in_stall;
    wire                   o_out_valid;
    wire  [CHAR_W-1:0]     o_digit_char;
    wire                   o_last_digit;

    // predicted characters of all accepted items, oldest first
    t_digit      pending_chars[$];
    int unsigned mismatches   = 0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;
    // when low, neither side inserts gaps or stalls
    bit          idle_on      = 1'b1;

    unsigned_to_radix_digits_unit #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_value      (in_value),
        .i_radix      (in_radix),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // digit prediction
    // ------------------------------------------------------------------------

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] g;
        if (d < DECIMAL_LIMIT) begin
            g = CHAR_ZERO + CHAR_W'(d);
        end else begin
            g = CHAR_LOWER_A + CHAR_W'(d - DECIMAL_LIMIT);
        end
        return g;
    endfunction

    // split a value into radix digits and queue their characters, msd first
    function automatic void expand_digits(input logic [IN_VALUE_W-1:0] value,
                                          input logic [RADIX_W-1:0]    radix);
        logic [IN_VALUE_W-1:0] quot;
        logic [IN_VALUE_W-1:0] base;
        logic [RADIX_W-1:0]    rem_digits[MAX_DIGITS];
        int                    n;
        t_digit                c;
        // only the low VALUE_WIDTH bits count
        quot = (VALUE_WIDTH >= IN_VALUE_W) ? value
                                           : value & ((64'd1 << VALUE_WIDTH) - 64'd1);
        // out-of-range radix is clamped
        if (radix < RADIX_MIN) begin
            base = IN_VALUE_W'(RADIX_MIN);
        end else if (radix > RADIX_MAX) begin
            base = IN_VALUE_W'(RADIX_MAX);
        end else begin
            base = IN_VALUE_W'(radix);
        end
        n = 0;
        // zero still gives one digit; a full buffer keeps the low digits
        do begin
            rem_digits[n] = RADIX_W'(quot % base);
            n++;
            quot = quot / base;
        end while (quot != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            c.ch   = digit_glyph(rem_digits[k]);
            c.last = (k == 0);
            pending_chars.push_back(c);
        end
    endfunction

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // offer one item; returns at the edge where it is accepted with valid
    // still high, so a following call with no gap keeps the stream dense
    task automatic push_number(input logic [IN_VALUE_W-1:0] value,
                               input logic [RADIX_W-1:0]    radix);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_value <= value;
        in_radix <= radix;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expand_digits(value, radix);
    endtask

    // drop valid and hold off until every predicted digit has come out
    task automatic wait_for_all_digits();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // digit checker and receiver stalls
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin : digit_sink
        t_digit      want;
        int unsigned hold;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (pending_chars.size() == 0) begin
                    $display("%0t: unexpected digit char %h last %b", $time,
                             o_digit_char, o_last_digit);
                    mismatches++;
                end else begin
                    want = pending_chars.pop_front();
                    if (o_digit_char !== want.ch) begin
                        $display("%0t: digit char expected %h actual %h", $time,
                                 want.ch, o_digit_char);
                        mismatches++;
                    end
                    if (o_last_digit !== want.last) begin
                        $display("%0t: last flag expected %b actual %b", $time,
                                 want.last, o_last_digit);
                        mismatches++;
                    end
                end
                // fresh stall draw for the next digit
                hold = idle_on ? $urandom_range(0, 6) : 0;
                if (hold > 0) begin
                    out_stall  <= 1'b1;
                    stall_left = hold;
                end
            end else if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // end the run if nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // zero and one- or two-character results, both ends of the letter range
    task automatic test_short_numbers();
        push_number(64'd0, 6'd10);
        push_number(64'd0, 6'd0);
        push_number(64'd0, 6'd63);
        push_number(64'd1, 6'd2);
        push_number(64'd9, 6'd10);
        push_number(64'd10, 6'd11);
        push_number(64'd35, 6'd36);
        push_number(64'd36, 6'd36);
    endtask

    // radix below two acts as two, above thirty-six as thirty-six
    task automatic test_radix_clamping();
        push_number(64'd5, 6'd0);
        push_number(64'd5, 6'd1);
        push_number(64'd100, 6'd37);
        push_number(64'd12345, 6'd63);
        push_number(64'd255, 6'd16);
        push_number(64'd1295, 6'd36);
    endtask

    // full-width values, up to the longest string of 64 binary digits
    task automatic test_full_width();
        push_number('1, 6'd2);
        push_number('1, 6'd36);
        push_number('1, 6'd10);
        push_number(64'h8000_0000_0000_0000, 6'd2);
        push_number(64'h8000_0000_0000_0000, 6'd0);
        push_number(64'haaaa_aaaa_aaaa_aaaa, 6'd3);
        push_number(64'h5555_5555_5555_5555, 6'd7);
        push_number('1, 6'd16);
    endtask

    // random values and radices in segments, some with no idling; halfway
    // the sender holds off until the unit has drained
    task automatic test_random_numbers();
        logic [IN_VALUE_W-1:0] value;
        logic [RADIX_W-1:0]    radix;
        int unsigned           kind;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 15 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if (i == RANDOM_ITEMS / 2) begin
                wait_for_all_digits();
            end
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                value = 64'($urandom_range(0, 100));
            end else if (kind < 4) begin
                value = {$urandom, $urandom};
            end else begin
                // spread digit counts over the whole range
                value = {$urandom, $urandom} >> $urandom_range(0, 63);
            end
            if ($urandom_range(0, 4) == 0) begin
                radix = RADIX_W'($urandom_range(0, 63));
            end else begin
                radix = RADIX_W'($urandom_range(2, 36));
            end
            push_number(value, radix);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_numbers();
        test_radix_clamping();
        test_full_width();
        test_random_numbers();

        wait_for_all_digits();
        // a few digit times for anything stray to show up
        repeat (300) @(posedge i_clk);

        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
